[hw/rtl/spms_pkg.sv]
// shared constants, types and helper functions of the mailbox scheduler
`default_nettype none

package spms_pkg;

    localparam int LEVEL_COUNT  = 4;
    localparam int NUM_BOXES    = 16;
    localparam int BOX_CAPACITY = 255;

    localparam int BOX_W       = 4;
    localparam int MASK_BITS   = 16;
    localparam int MAP_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int STATUS_W    = 2;
    localparam int LEVEL_OUT_W = 2;

    localparam int LIVE_BOXES = (NUM_BOXES < MASK_BITS) ? NUM_BOXES : MASK_BITS;
    localparam int BIX_W      = $clog2(LIVE_BOXES);
    localparam int LV_W       = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
    localparam int SLOT_W     = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
    localparam int FILL_W     = $clog2(NUM_BOXES + 1);
    localparam int SUM_W      = FILL_W + 1;
    localparam int CNT_W      = $clog2(BOX_CAPACITY + 1);
    localparam int QDEPTH     = LEVEL_COUNT * NUM_BOXES;
    localparam int QA_W       = $clog2(QDEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRIORITY_MAP,
        CFG_MONITORED,
        CFG_RESOLVABLE
    } cfg_index_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DELIVERED,
        STATUS_UNRESOLVABLE,
        STATUS_OVERFLOW,
        STATUS_NOTHING_READY
    } status_t;

    typedef enum logic {
        MODE_SUBMIT,
        MODE_STEP
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP,
        ST_SERVE
    } state_t;

    typedef struct packed {
        logic [MAP_W-1:0]     prio_map;
        logic [MASK_BITS-1:0] monitored;
        logic [MASK_BITS-1:0] resolvable;
    } cfg_t;

    typedef struct packed {
        status_t                status;
        logic                   served_valid;
        logic [BOX_W-1:0]       served_box;
        logic [LEVEL_OUT_W-1:0] served_level;
    } rsp_t;

    // map level, clamped to the lowest level that exists
    function automatic logic [LV_W-1:0] box_level(input logic [MAP_W-1:0] map,
                                                  input logic [BOX_W-1:0] box);
        logic [1:0] raw;
        raw = map[2*box +: 2];
        if (int'(raw) >= LEVEL_COUNT)
            return LV_W'(LEVEL_COUNT - 1);
        return LV_W'(raw);
    endfunction

    function automatic logic box_flag(input logic [MASK_BITS-1:0] mask,
                                      input logic [BOX_W-1:0] box);
        return (int'(box) < LIVE_BOXES) && mask[box];
    endfunction

    // ring position head + offset, wrapped at the ring length of one level (NUM_BOXES)
    function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] head,
                                                     input logic [FILL_W-1:0] offset);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(offset);
        if (sum >= SUM_W'(NUM_BOXES))
            sum = sum - SUM_W'(NUM_BOXES);
        return SLOT_W'(sum);
    endfunction

    function automatic logic [QA_W-1:0] qaddr(input logic [LV_W-1:0] lv,
                                              input logic [SLOT_W-1:0] slot);
        return QA_W'(int'(lv) * NUM_BOXES + int'(slot));
    endfunction

endpackage

`default_nettype wire

[hw/rtl/spms_if.sv]
// request and result channel interfaces of the mailbox scheduler
`default_nettype none

interface spms_req_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [3:0] box_id;

    modport source (output valid, output mode, output box_id, input ready);
    modport sink (input valid, input mode, input box_id, output ready);
endinterface

interface spms_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       served_valid;
    logic [3:0] served_box;
    logic [1:0] served_level;

    modport source (output valid, output status, output served_valid,
                    output served_box, output served_level, input ready);
    modport sink (input valid, input status, input served_valid,
                  input served_box, input served_level, output ready);
endinterface

`default_nettype wire

[hw/rtl/spms_ram.sv]
// generic simple dual-port ram with registered read
`default_nettype none

module spms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/spms_sched.sv]
// sequencer: count and queue memories, ring pointers, ready marks
`default_nettype none

module spms_sched
    import spms_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    spms_req_if.sink  req,
    input  wire logic slot_free,
    output logic      res_valid,
    output rsp_t      res
);

    state_t state_reg, state_next;

    logic               mode_reg;
    logic [BOX_W-1:0]   box_reg;
    logic [LV_W-1:0]    lvl_reg;
    logic [BOX_W-1:0]   sbox_reg;

    logic [SLOT_W-1:0]  head_reg [LEVEL_COUNT];
    logic [FILL_W-1:0]  fill_reg [LEVEL_COUNT];
    logic [LIVE_BOXES-1:0] ready_reg;
    logic [LIVE_BOXES-1:0] pvld_reg;

    logic               accept;
    logic               any_ready;
    logic [LV_W-1:0]    top_lvl;

    logic               p_we, p_re;
    logic [BIX_W-1:0]   p_waddr, p_raddr;
    logic [CNT_W-1:0]   p_wdata, p_rdata;
    logic               q_we, q_re;
    logic [QA_W-1:0]    q_waddr, q_raddr;
    logic [BOX_W-1:0]   q_rdata;

    logic [BOX_W-1:0]   cur_box;
    logic [BIX_W-1:0]   cur_bix;
    logic [CNT_W-1:0]   cnt;
    logic [CNT_W-1:0]   cnt_dec;

    logic               pop;
    logic               clear_ready;
    logic               push_req;
    logic [LV_W-1:0]    push_lvl;
    logic               push_ok;

    assign accept = req.valid && req.ready;

    // highest nonempty level, level 0 wins
    always_comb
    begin
        any_ready = 1'b0;
        top_lvl   = '0;
        for (int i = LEVEL_COUNT - 1; i >= 0; i--)
        begin
            if (fill_reg[i] != '0)
            begin
                any_ready = 1'b1;
                top_lvl   = LV_W'(i);
            end
        end
    end

    spms_ram #(.WIDTH(CNT_W), .DEPTH(LIVE_BOXES)) u_count_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .re    (p_re),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    spms_ram #(.WIDTH(BOX_W), .DEPTH(QDEPTH)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (cur_box),
        .re    (q_re),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    // count ram: read at accept for a submit, in the pop state for a served step
    assign p_re    = accept || (state_reg == ST_POP);
    assign p_raddr = (state_reg == ST_POP) ? BIX_W'(q_rdata) : BIX_W'(req.box_id);
    assign q_re    = accept && (req.mode == MODE_STEP) && any_ready;
    assign q_raddr = qaddr(top_lvl, head_reg[top_lvl]);

    assign cur_box = (state_reg == ST_SERVE) ? sbox_reg : box_reg;
    assign cur_bix = BIX_W'(cur_box);
    assign p_waddr = cur_bix;
    // entries never written read as zero
    assign cnt     = pvld_reg[cur_bix] ? p_rdata : '0;
    assign cnt_dec = (cnt != '0) ? cnt - CNT_W'(1) : '0;

    assign push_lvl = box_level(cfg.prio_map, cur_box);
    assign push_ok  = push_req && (int'(fill_reg[push_lvl]) < NUM_BOXES);
    assign q_we     = push_ok;
    assign q_waddr  = qaddr(push_lvl, slot_after(head_reg[push_lvl], fill_reg[push_lvl]));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((req.mode == MODE_STEP) && any_ready)
                        state_next = ST_POP;
                    else
                        state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            ST_POP:
            begin
                state_next = ST_SERVE;
            end
            ST_SERVE:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath actions
    always_comb
    begin
        req.ready   = (state_reg == ST_IDLE);
        res_valid   = 1'b0;
        res         = '0;
        p_we        = 1'b0;
        p_wdata     = cnt;
        pop         = 1'b0;
        clear_ready = 1'b0;
        push_req    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    res_valid = 1'b1;
                    if (mode_reg == MODE_STEP)
                    begin
                        res.status = STATUS_NOTHING_READY;
                    end
                    else if (!box_flag(cfg.resolvable, box_reg))
                    begin
                        res.status = STATUS_UNRESOLVABLE;
                    end
                    else
                    begin
                        if (int'(cnt) >= BOX_CAPACITY)
                        begin
                            res.status = STATUS_OVERFLOW;
                        end
                        else
                        begin
                            res.status = STATUS_DELIVERED;
                            p_we       = 1'b1;
                            p_wdata    = cnt + CNT_W'(1);
                        end
                        push_req = box_flag(cfg.monitored, box_reg) && !ready_reg[cur_bix];
                    end
                end
            end
            ST_POP:
            begin
                pop = 1'b1;
            end
            ST_SERVE:
            begin
                if (slot_free)
                begin
                    res_valid        = 1'b1;
                    res.status       = STATUS_DELIVERED;
                    res.served_valid = 1'b1;
                    res.served_box   = sbox_reg;
                    res.served_level = LEVEL_OUT_W'(lvl_reg);
                    clear_ready      = 1'b1;
                    p_we             = 1'b1;
                    p_wdata          = cnt_dec;
                    // ready mark is cleared this cycle, so only the count and mask gate it
                    push_req = (cnt_dec != '0) && box_flag(cfg.monitored, sbox_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= '0;
            pvld_reg  <= '0;
            for (int i = 0; i < LEVEL_COUNT; i++)
            begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                head_reg[lvl_reg] <= slot_after(head_reg[lvl_reg], FILL_W'(1));
                fill_reg[lvl_reg] <= fill_reg[lvl_reg] - FILL_W'(1);
            end
            if (push_ok)
            begin
                fill_reg[push_lvl] <= fill_reg[push_lvl] + FILL_W'(1);
                ready_reg[cur_bix] <= 1'b1;
            end
            else if (clear_ready)
            begin
                ready_reg[cur_bix] <= 1'b0;
            end
            if (p_we)
            begin
                pvld_reg[p_waddr] <= 1'b1;
            end
        end
    end

    // request payload and popped box
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= req.mode;
            box_reg  <= req.box_id;
            lvl_reg  <= top_lvl;
        end
        if (state_reg == ST_POP)
        begin
            sbox_reg <= q_rdata;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/strict_priority_mailbox_scheduler.sv]
// Strict-priority mailbox scheduler, one ring queue per priority level.
// Channel req carries one request: mode (0 submit a message to box_id,
// 1 take one scheduling step). Channel rsp returns exactly one result per
// request: status, and for a served step the box and its level.
// Configuration registers (priority map, monitored mask, resolvable mask)
// are written through cfg_we / cfg_index / cfg_data; the user must write
// them only while the block is idle, the block itself does not enforce it.
// A submit or an empty step passes through the exec state; a served step
// passes through the pop and serve states, as the queue memory read of the
// front box and the count memory read of that box follow one another.
// Results land in an output register, so the next request is taken while
// the previous result is still waiting. If the receiver stalls, the
// sequencer holds its result stage until the register frees up.
// Reset clears the registers, the ring pointers and the ready marks, and
// marks all pending counts as zero; the block is usable right after reset.
`default_nettype none

module strict_priority_mailbox_scheduler
    import spms_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    spms_req_if.sink                   req,
    spms_rsp_if.source                 rsp,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;
    logic rsp_valid_reg;
    rsp_t rsp_data_reg;
    logic slot_free;
    logic res_valid;
    rsp_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PRIORITY_MAP: cfg_reg.prio_map   <= cfg_data[MAP_W-1:0];
                CFG_MONITORED:    cfg_reg.monitored  <= cfg_data[MASK_BITS-1:0];
                CFG_RESOLVABLE:   cfg_reg.resolvable <= cfg_data[MASK_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign slot_free = !rsp_valid_reg || rsp.ready;

    spms_sched u_sched (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req       (req),
        .slot_free (slot_free),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_data_reg.status;
    assign rsp.served_valid = rsp_data_reg.served_valid;
    assign rsp.served_box   = rsp_data_reg.served_box;
    assign rsp.served_level = rsp_data_reg.served_level;

endmodule

`default_nettype wire
